// ----- rtl/core/keyframe_polygon_interpolator_core_macros.svh -----
// Assertion macros shared by the keyframe polygon interpolator RTL.
// Included by the top level; depends on nothing else.
`ifndef KEYFRAME_POLYGON_INTERPOLATOR_CORE_MACROS_SVH
`define KEYFRAME_POLYGON_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KPI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/kpi_pkg.sv -----
// Types, constants and command encodings of the keyframe polygon interpolator.
// Used by kpi_ctrl, kpi_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package kpi_pkg;

  localparam int MAX_ANCHORS  = 256;
  localparam int AIDX_W       = $clog2(MAX_ANCHORS);
  localparam int ACNT_W       = AIDX_W + 1;
  localparam int MAX_VERTICES = 64;
  localparam int VCNT_W       = 7;
  localparam int SLICE_W      = 10;
  localparam int VERT_W       = 6;
  localparam int COORD_W      = 16;
  localparam int CFG_W        = 11;
  localparam int NUM_W        = 27;
  localparam int MAG_W        = 25;
  localparam int DCNT_W       = 5;

  typedef enum logic [1:0] {
    REQ_SET        = 2'd0,
    REQ_QUERY      = 2'd1,
    REQ_INS_ANCHOR = 2'd2,
    REQ_INS_MID    = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LK_QUERY,
    LK_BEFORE,
    LK_AFTER
  } lk_sel_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_CHECK, OP_SET_SCAN, OP_SET_WRITE, OP_SHIFT, OP_INS_APPEND,
    OP_RING, OP_FIND, OP_MID_CHK, OP_LK_SCAN, OP_MUL1, OP_MUL2, OP_DIV_INIT,
    OP_DIV, OP_LK_RES, OP_MID_APPEND, OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_SET_SCAN, S_SET_WRITE, S_SHIFT, S_INS_APPEND,
    S_RING, S_FIND, S_MID_CHK, S_LK_SCAN, S_MUL1, S_MUL2, S_DIV_INIT,
    S_DIV, S_LK_RES, S_MID_APPEND, S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [SLICE_W-1:0]        slice;
    logic [VERT_W-1:0]         vert;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } anchor_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [SLICE_W-1:0]        slice_no;
    logic [VERT_W-1:0]         vert_no;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      anchor_here;
    logic [1:0]                status;
  } out_res_t;

  typedef struct packed {
    dp_op_t  op;
    lk_sel_t lk_sel;
    logic    in_ready;
  } ctl_cmd_t;

  typedef struct packed {
    req_kind_t req_kind;
    logic      range_bad;
    logic      vfull;
    logic      scan_done;
    logic      best_found;
    logic      lk_interp;
    logic      div_last;
    logic      out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/keyframe_polygon_interpolator_core.sv -----
// Keyframe polygon interpolator: anchor table with linear interpolation
// across slices. One request in, one response out, both valid/ready.
// The cfg_ channel writes slice_count (11 bits) and is always ready; write it
// only while no request is in flight. Reset sets slice_count to 1 and empties
// the anchor table and the vertex count; no clearing pass is needed.
// Requests are handled one at a time. Every step that touches the table reads
// the single anchor memory port once per entry, so each request takes longer
// as more anchors are stored; an insert-midpoint scans the table again for each
// slice on which a neighbour has an anchor, and a query that interpolates also
// passes through the multiply states S_MUL1 and S_MUL2, the divider setup state
// S_DIV_INIT and the serial divider state S_DIV. The next request is taken the
// cycle after the response is loaded. Response values are registered; a new
// request is taken while the previous response still waits, and a stalled
// receiver only holds the block once the next response is ready to be loaded.
`timescale 1ns / 1ps
`include "keyframe_polygon_interpolator_core_macros.svh"

module keyframe_polygon_interpolator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  kpi_pkg::in_req_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output kpi_pkg::out_res_t          out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kpi_pkg::CFG_W-1:0]  cfg_data
);

  kpi_pkg::ctl_cmd_t cmd;
  kpi_pkg::dp_stat_t stat;

  kpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  kpi_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

  assign in_ready  = cmd.in_ready;
  assign cfg_ready = 1'b1;

  `KPI_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "accepted request did not make the block busy")
  `KPI_ASSERT_NEXT(a_emit_loads_output, clk, rst_n, cmd.op == kpi_pkg::OP_EMIT && stat.out_free, out_valid && in_ready, "response load did not present a response")
  `KPI_ASSERT_IMPLIES(a_anchor_flag_ok, clk, rst_n, out_valid && out_data.anchor_here, out_data.status == 2'(kpi_pkg::ST_OK), "anchor flag set on a failed request")

endmodule

// ----- rtl/core/kpi_ctrl.sv -----
// Sequencing state machine of the keyframe polygon interpolator.
// Depends on kpi_pkg; drives the datapath through ctl_cmd_t.
`timescale 1ns / 1ps

module kpi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  kpi_pkg::dp_stat_t  stat,
  output kpi_pkg::ctl_cmd_t  cmd
);

  kpi_pkg::ctrl_state_t state_r, state_nxt;
  kpi_pkg::lk_sel_t     lk_sel_r, lk_sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= kpi_pkg::S_IDLE;
      lk_sel_r <= kpi_pkg::LK_QUERY;
    end else begin
      state_r  <= state_nxt;
      lk_sel_r <= lk_sel_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    lk_sel_nxt = lk_sel_r;
    unique case (state_r)
      kpi_pkg::S_IDLE: begin
        if (in_valid) state_nxt = kpi_pkg::S_CHECK;
      end
      kpi_pkg::S_CHECK: begin
        if (stat.range_bad || stat.vfull) begin
          state_nxt = kpi_pkg::S_DONE;
        end else begin
          unique case (stat.req_kind)
            kpi_pkg::REQ_SET: state_nxt = kpi_pkg::S_SET_SCAN;
            kpi_pkg::REQ_QUERY: begin
              state_nxt  = kpi_pkg::S_LK_SCAN;
              lk_sel_nxt = kpi_pkg::LK_QUERY;
            end
            kpi_pkg::REQ_INS_ANCHOR, kpi_pkg::REQ_INS_MID: state_nxt = kpi_pkg::S_SHIFT;
          endcase
        end
      end
      kpi_pkg::S_SET_SCAN: begin
        if (stat.scan_done) state_nxt = kpi_pkg::S_SET_WRITE;
      end
      kpi_pkg::S_SET_WRITE: state_nxt = kpi_pkg::S_DONE;
      kpi_pkg::S_SHIFT: begin
        if (stat.scan_done) begin
          if (stat.req_kind == kpi_pkg::REQ_INS_ANCHOR) state_nxt = kpi_pkg::S_INS_APPEND;
          else state_nxt = kpi_pkg::S_RING;
        end
      end
      kpi_pkg::S_INS_APPEND: state_nxt = kpi_pkg::S_DONE;
      kpi_pkg::S_RING: state_nxt = kpi_pkg::S_FIND;
      kpi_pkg::S_FIND: begin
        if (stat.scan_done) state_nxt = kpi_pkg::S_MID_CHK;
      end
      kpi_pkg::S_MID_CHK: begin
        if (stat.best_found) begin
          state_nxt  = kpi_pkg::S_LK_SCAN;
          lk_sel_nxt = kpi_pkg::LK_BEFORE;
        end else begin
          state_nxt = kpi_pkg::S_DONE;
        end
      end
      kpi_pkg::S_LK_SCAN: begin
        if (stat.scan_done) begin
          if (stat.lk_interp) state_nxt = kpi_pkg::S_MUL1;
          else state_nxt = kpi_pkg::S_LK_RES;
        end
      end
      kpi_pkg::S_MUL1: state_nxt = kpi_pkg::S_MUL2;
      kpi_pkg::S_MUL2: state_nxt = kpi_pkg::S_DIV_INIT;
      kpi_pkg::S_DIV_INIT: state_nxt = kpi_pkg::S_DIV;
      kpi_pkg::S_DIV: begin
        if (stat.div_last) state_nxt = kpi_pkg::S_LK_RES;
      end
      kpi_pkg::S_LK_RES: begin
        unique case (lk_sel_r)
          kpi_pkg::LK_QUERY: state_nxt = kpi_pkg::S_DONE;
          kpi_pkg::LK_BEFORE: begin
            state_nxt  = kpi_pkg::S_LK_SCAN;
            lk_sel_nxt = kpi_pkg::LK_AFTER;
          end
          default: state_nxt = kpi_pkg::S_MID_APPEND;
        endcase
      end
      kpi_pkg::S_MID_APPEND: state_nxt = kpi_pkg::S_FIND;
      kpi_pkg::S_DONE: begin
        if (stat.out_free) state_nxt = kpi_pkg::S_IDLE;
      end
      default: state_nxt = kpi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.lk_sel   = lk_sel_r;
    cmd.in_ready = (state_r == kpi_pkg::S_IDLE);
    unique case (state_r)
      kpi_pkg::S_IDLE:       cmd.op = kpi_pkg::OP_IDLE;
      kpi_pkg::S_CHECK:      cmd.op = kpi_pkg::OP_CHECK;
      kpi_pkg::S_SET_SCAN:   cmd.op = kpi_pkg::OP_SET_SCAN;
      kpi_pkg::S_SET_WRITE:  cmd.op = kpi_pkg::OP_SET_WRITE;
      kpi_pkg::S_SHIFT:      cmd.op = kpi_pkg::OP_SHIFT;
      kpi_pkg::S_INS_APPEND: cmd.op = kpi_pkg::OP_INS_APPEND;
      kpi_pkg::S_RING:       cmd.op = kpi_pkg::OP_RING;
      kpi_pkg::S_FIND:       cmd.op = kpi_pkg::OP_FIND;
      kpi_pkg::S_MID_CHK:    cmd.op = kpi_pkg::OP_MID_CHK;
      kpi_pkg::S_LK_SCAN:    cmd.op = kpi_pkg::OP_LK_SCAN;
      kpi_pkg::S_MUL1:       cmd.op = kpi_pkg::OP_MUL1;
      kpi_pkg::S_MUL2:       cmd.op = kpi_pkg::OP_MUL2;
      kpi_pkg::S_DIV_INIT:   cmd.op = kpi_pkg::OP_DIV_INIT;
      kpi_pkg::S_DIV:        cmd.op = kpi_pkg::OP_DIV;
      kpi_pkg::S_LK_RES:     cmd.op = kpi_pkg::OP_LK_RES;
      kpi_pkg::S_MID_APPEND: cmd.op = kpi_pkg::OP_MID_APPEND;
      kpi_pkg::S_DONE:       cmd.op = kpi_pkg::OP_EMIT;
      default:               cmd.op = kpi_pkg::OP_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/kpi_datapath.sv -----
// Datapath of the keyframe polygon interpolator: anchor memory, scan logic,
// interpolation multiplier and serial dividers, output register. Uses kpi_pkg.
`timescale 1ns / 1ps

module kpi_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kpi_pkg::in_req_t             in_data,
  input  logic                         in_valid,
  input  logic                         cfg_valid,
  input  logic [kpi_pkg::CFG_W-1:0]    cfg_data,
  input  kpi_pkg::ctl_cmd_t            cmd,
  input  logic                         out_ready,
  output kpi_pkg::dp_stat_t            stat,
  output kpi_pkg::out_res_t            out_data,
  output logic                         out_valid
);

  localparam int AW = kpi_pkg::AIDX_W;
  localparam int CW = kpi_pkg::ACNT_W;
  localparam int SW = kpi_pkg::SLICE_W;
  localparam int VW = kpi_pkg::VERT_W;
  localparam int XW = kpi_pkg::COORD_W;
  localparam int NW = kpi_pkg::NUM_W;
  localparam int MW = kpi_pkg::MAG_W;

  // Average of two coordinates, rounded half away from zero.
  function automatic logic signed [XW-1:0] half_away(input logic signed [XW-1:0] a,
                                                     input logic signed [XW-1:0] b);
    logic signed [XW+1:0] s;
    logic signed [XW+1:0] m;
    s = (XW+2)'(a) + (XW+2)'(b);
    m = s[XW+1] ? -s : s;
    m = (m + (XW+2)'(1)) >>> 1;
    if (s[XW+1]) m = -m;
    return m[XW-1:0];
  endfunction

  kpi_pkg::anchor_t mem [kpi_pkg::MAX_ANCHORS];
  kpi_pkg::anchor_t rd_q_r;

  kpi_pkg::in_req_t   req_r;
  logic [kpi_pkg::CFG_W-1:0]  slice_cnt_r;
  logic [CW-1:0]              count_r;
  logic [kpi_pkg::VCNT_W-1:0] vc_r;
  kpi_pkg::status_t           st_r;

  logic [CW-1:0] scan_i_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;

  logic          match_r;
  logic [AW-1:0] match_idx_r;
  logic [VW-1:0] before_r, after_r;
  logic [CW-1:0] base_r;
  logic [SW-1:0] prev_r, best_r;
  logic          have_prev_r, found_r;

  logic                 f1_r, f2_r;
  logic [SW-1:0]        s1_r, s2_r;
  logic signed [XW-1:0] x1_r, y1_r, x2_r, y2_r;

  logic signed [NW-1:0] nx_r, ny_r;
  logic                 negx_r, negy_r;
  logic [SW-1:0]        remx_r, remy_r, d_r;
  logic [MW-1:0]        qx_r, qy_r;
  logic [kpi_pkg::DCNT_W-1:0] dcnt_r;

  logic signed [XW-1:0] bx_r, by_r, resx_r, resy_r;
  logic                 here_r;

  kpi_pkg::out_res_t out_r;
  logic              out_vld_r;

  kpi_pkg::req_kind_t kind;
  logic is_ins, s_oor, p_ge_vc, p_gt_vc, vc_full, range_bad, vfull;
  logic is_scan, scan_first, issue, scan_done, out_free, emit_load;
  logic [CW-1:0] scan_lim;
  kpi_pkg::anchor_t ent;
  logic [SW-1:0] ls;
  logic [VW-1:0] lv;
  logic exact, lk_interp;
  logic mem_we;
  logic [AW-1:0] mem_wa;
  kpi_pkg::anchor_t mem_wd, app_ent;
  logic do_append;
  logic [SW:0] trx, try_;
  logic ge_x, ge_y;
  logic signed [XW-1:0] valx, valy;
  logic [SW-1:0] w_mul, t_mul;
  logic [VW:0] p_inc;

  assign kind    = kpi_pkg::req_kind_t'(req_r.req_type);
  assign is_ins  = (kind == kpi_pkg::REQ_INS_ANCHOR) || (kind == kpi_pkg::REQ_INS_MID);
  assign s_oor   = {1'b0, req_r.slice_no} >= slice_cnt_r;
  assign p_ge_vc = {1'b0, req_r.vert_no} >= vc_r;
  assign p_gt_vc = {1'b0, req_r.vert_no} > vc_r;
  assign vc_full = vc_r == kpi_pkg::VCNT_W'(kpi_pkg::MAX_VERTICES);
  assign vfull   = is_ins && vc_full;

  always_comb begin
    unique case (kind)
      kpi_pkg::REQ_SET, kpi_pkg::REQ_QUERY: range_bad = s_oor || p_ge_vc;
      kpi_pkg::REQ_INS_ANCHOR:              range_bad = p_gt_vc || s_oor;
      kpi_pkg::REQ_INS_MID:                 range_bad = p_gt_vc;
    endcase
  end

  // Table scans issue one read a cycle; the entry comes back registered in rd_q_r.
  assign is_scan = (cmd.op == kpi_pkg::OP_SET_SCAN) || (cmd.op == kpi_pkg::OP_SHIFT) ||
                   (cmd.op == kpi_pkg::OP_FIND) || (cmd.op == kpi_pkg::OP_LK_SCAN);
  assign scan_lim   = (cmd.op == kpi_pkg::OP_FIND) ? base_r : count_r;
  assign issue      = is_scan && (scan_i_r < scan_lim);
  assign scan_first = is_scan && (scan_i_r == '0) && !rd_vld_r;
  assign scan_done  = is_scan && !issue && !rd_vld_r;
  assign ent        = rd_q_r;

  always_comb begin
    unique case (cmd.lk_sel)
      kpi_pkg::LK_QUERY: begin
        ls = req_r.slice_no;
        lv = req_r.vert_no;
      end
      kpi_pkg::LK_BEFORE: begin
        ls = best_r;
        lv = before_r;
      end
      default: begin
        ls = best_r;
        lv = after_r;
      end
    endcase
  end

  assign exact     = f1_r && (s1_r == ls);
  assign lk_interp = f1_r && f2_r && !exact;
  assign w_mul     = s2_r - ls;
  assign t_mul     = ls - s1_r;

  // Memory write port.
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = count_r[AW-1:0];
    mem_wd    = ent;
    app_ent   = '{slice: req_r.slice_no, vert: req_r.vert_no,
                  x: req_r.coord_x, y: req_r.coord_y};
    do_append = 1'b0;
    unique case (cmd.op)
      kpi_pkg::OP_SHIFT: begin
        if (rd_vld_r && (ent.vert >= req_r.vert_no)) begin
          mem_we      = 1'b1;
          mem_wa      = rd_idx_r;
          mem_wd      = ent;
          mem_wd.vert = ent.vert + VW'(1);
        end
      end
      kpi_pkg::OP_SET_WRITE: begin
        if (match_r) begin
          mem_we = 1'b1;
          mem_wa = match_idx_r;
          mem_wd = app_ent;
        end else begin
          do_append = 1'b1;
        end
      end
      kpi_pkg::OP_INS_APPEND: do_append = 1'b1;
      kpi_pkg::OP_MID_APPEND: begin
        do_append = 1'b1;
        app_ent   = '{slice: best_r, vert: req_r.vert_no,
                      x: half_away(bx_r, resx_r), y: half_away(by_r, resy_r)};
      end
      default: mem_we = 1'b0;
    endcase
    if (do_append && !count_r[CW-1]) begin
      mem_we = 1'b1;
      mem_wa = count_r[AW-1:0];
      mem_wd = app_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (issue) rd_q_r <= mem[scan_i_r[AW-1:0]];
  end

  // Serial restoring divider step, one quotient bit per cycle for x and y.
  assign trx  = {remx_r, qx_r[MW-1]};
  assign try_ = {remy_r, qy_r[MW-1]};
  assign ge_x = trx >= {1'b0, d_r};
  assign ge_y = try_ >= {1'b0, d_r};

  always_comb begin
    priority if (exact) begin
      valx = x1_r;
      valy = y1_r;
    end else if (f1_r && f2_r) begin
      valx = negx_r ? -qx_r[XW-1:0] : qx_r[XW-1:0];
      valy = negy_r ? -qy_r[XW-1:0] : qy_r[XW-1:0];
    end else if (f1_r) begin
      valx = x1_r;
      valy = y1_r;
    end else if (f2_r) begin
      valx = x2_r;
      valy = y2_r;
    end else begin
      valx = '0;
      valy = '0;
    end
  end

  assign p_inc     = {1'b0, req_r.vert_no} + (VW+1)'(1);
  assign out_free  = !out_vld_r || out_ready;
  assign emit_load = (cmd.op == kpi_pkg::OP_EMIT) && out_free;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_cnt_r <= kpi_pkg::CFG_W'(1);
      count_r     <= '0;
      vc_r        <= '0;
      scan_i_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_valid) slice_cnt_r <= cfg_data;
      if (!is_scan) begin
        scan_i_r <= '0;
        rd_vld_r <= 1'b0;
      end else begin
        if (issue) scan_i_r <= scan_i_r + CW'(1);
        rd_vld_r <= issue;
      end
      if (cmd.op == kpi_pkg::OP_CHECK && is_ins && !range_bad && !vc_full) begin
        vc_r <= vc_r + kpi_pkg::VCNT_W'(1);
      end
      if (do_append && !count_r[CW-1]) count_r <= count_r + CW'(1);
      if (emit_load) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_i_r[AW-1:0];
    if (cmd.in_ready && in_valid) req_r <= in_data;
    if (do_append && count_r[CW-1]) st_r <= kpi_pkg::ST_FULL;
    unique case (cmd.op)
      kpi_pkg::OP_CHECK: begin
        if (range_bad) st_r <= kpi_pkg::ST_RANGE;
        else if (vfull) st_r <= kpi_pkg::ST_FULL;
        else st_r <= kpi_pkg::ST_OK;
      end
      kpi_pkg::OP_SET_SCAN: begin
        if (scan_first) match_r <= 1'b0;
        if (rd_vld_r && ent.slice == req_r.slice_no && ent.vert == req_r.vert_no) begin
          match_r     <= 1'b1;
          match_idx_r <= rd_idx_r;
        end
      end
      kpi_pkg::OP_RING: begin
        before_r    <= (req_r.vert_no == '0) ? VW'(vc_r - kpi_pkg::VCNT_W'(1))
                                             : req_r.vert_no - VW'(1);
        after_r     <= (p_inc >= vc_r) ? '0 : p_inc[VW-1:0];
        base_r      <= count_r;
        have_prev_r <= 1'b0;
      end
      kpi_pkg::OP_FIND: begin
        if (scan_first) found_r <= 1'b0;
        if (rd_vld_r && (ent.vert == before_r || ent.vert == after_r) &&
            (!have_prev_r || ent.slice > prev_r) && (!found_r || ent.slice < best_r)) begin
          found_r <= 1'b1;
          best_r  <= ent.slice;
        end
      end
      kpi_pkg::OP_MID_CHK: begin
        prev_r      <= best_r;
        have_prev_r <= 1'b1;
      end
      kpi_pkg::OP_LK_SCAN: begin
        if (scan_first) begin
          f1_r <= 1'b0;
          f2_r <= 1'b0;
        end
        if (rd_vld_r && ent.vert == lv) begin
          if (ent.slice <= ls) begin
            if (!f1_r || ent.slice > s1_r) begin
              f1_r <= 1'b1;
              s1_r <= ent.slice;
              x1_r <= ent.x;
              y1_r <= ent.y;
            end
          end else if (!f2_r || ent.slice < s2_r) begin
            f2_r <= 1'b1;
            s2_r <= ent.slice;
            x2_r <= ent.x;
            y2_r <= ent.y;
          end
        end
      end
      kpi_pkg::OP_MUL1: begin
        nx_r <= x1_r * $signed({1'b0, w_mul});
        ny_r <= y1_r * $signed({1'b0, w_mul});
        d_r  <= s2_r - s1_r;
      end
      kpi_pkg::OP_MUL2: begin
        nx_r <= nx_r + x2_r * $signed({1'b0, t_mul});
        ny_r <= ny_r + y2_r * $signed({1'b0, t_mul});
      end
      kpi_pkg::OP_DIV_INIT: begin
        negx_r <= nx_r[NW-1];
        negy_r <= ny_r[NW-1];
        qx_r   <= nx_r[NW-1] ? MW'(-nx_r) : MW'(nx_r);
        qy_r   <= ny_r[NW-1] ? MW'(-ny_r) : MW'(ny_r);
        remx_r <= '0;
        remy_r <= '0;
        dcnt_r <= kpi_pkg::DCNT_W'(MW);
      end
      kpi_pkg::OP_DIV: begin
        remx_r <= ge_x ? SW'(trx - {1'b0, d_r}) : trx[SW-1:0];
        remy_r <= ge_y ? SW'(try_ - {1'b0, d_r}) : try_[SW-1:0];
        qx_r   <= {qx_r[MW-2:0], ge_x};
        qy_r   <= {qy_r[MW-2:0], ge_y};
        dcnt_r <= dcnt_r - kpi_pkg::DCNT_W'(1);
      end
      kpi_pkg::OP_LK_RES: begin
        if (cmd.lk_sel == kpi_pkg::LK_BEFORE) begin
          bx_r <= valx;
          by_r <= valy;
        end else begin
          resx_r <= valx;
          resy_r <= valy;
          here_r <= exact;
        end
      end
      kpi_pkg::OP_EMIT: begin
        if (out_free) begin
          if (kind == kpi_pkg::REQ_QUERY && st_r == kpi_pkg::ST_OK) begin
            out_r.out_x       <= resx_r;
            out_r.out_y       <= resy_r;
            out_r.anchor_here <= here_r;
          end else begin
            out_r.out_x       <= '0;
            out_r.out_y       <= '0;
            out_r.anchor_here <= 1'b0;
          end
          out_r.status <= 2'(st_r);
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.req_kind   = kind;
  assign stat.range_bad  = range_bad;
  assign stat.vfull      = vfull;
  assign stat.scan_done  = scan_done;
  assign stat.best_found = found_r;
  assign stat.lk_interp  = lk_interp;
  assign stat.div_last   = dcnt_r == kpi_pkg::DCNT_W'(1);
  assign stat.out_free   = out_free;

  assign out_data  = out_r;
  assign out_valid = out_vld_r;

endmodule
